@@ sv/bmp_stream_pixel_decoder_assert.svh @@
// assertion macros shared by the bmp decoder rtl
`ifndef BMP_STREAM_PIXEL_DECODER_ASSERT_SVH
`define BMP_STREAM_PIXEL_DECODER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define BSPD_ASSERT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define BSPD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

@@ sv/bspd_pkg.sv @@
// shared constants and types of the bmp stream pixel decoder
`timescale 1ns / 1ps

package bspd_pkg;

	localparam int unsigned PAL_ENTRIES = 256;
	localparam int unsigned PAL_AW      = $clog2(PAL_ENTRIES);
	localparam int unsigned PAL_DW      = 24;

	localparam int unsigned DIM_W = 13;
	localparam int unsigned ROW_W = 15;

	localparam logic [31:0] MAX_DIM   = 32'd4096;
	localparam logic [31:0] HDR_BYTES = 32'd54;
	localparam logic [31:0] PAL_END_8 = HDR_BYTES + 32'(4 * PAL_ENTRIES);

	// header byte positions
	localparam logic [5:0] POS_MAGIC0 = 6'd0;
	localparam logic [5:0] POS_MAGIC1 = 6'd1;
	localparam logic [5:0] POS_OFFSET = 6'd10;
	localparam logic [5:0] POS_WIDTH  = 6'd18;
	localparam logic [5:0] POS_HEIGHT = 6'd22;
	localparam logic [5:0] POS_BPP    = 6'd28;
	localparam logic [5:0] POS_COMP   = 6'd30;
	localparam logic [5:0] POS_LAST   = 6'd53;

	localparam logic [7:0] MAGIC_B = 8'h42;
	localparam logic [7:0] MAGIC_M = 8'h4D;

	localparam logic [15:0] BPP_8  = 16'd8;
	localparam logic [15:0] BPP_24 = 16'd24;

	typedef enum logic [2:0] {
		ST_PIXEL      = 3'd0,
		ST_BAD_MAGIC  = 3'd1,
		ST_COMPRESSED = 3'd2,
		ST_BAD_DEPTH  = 3'd3,
		ST_TOO_LARGE  = 3'd4,
		ST_BAD_OFFSET = 3'd5
	} status_t;

endpackage

@@ sv/bmp_stream_pixel_decoder.sv @@
// bmp stream decoder top: header parse, palette load, pixel emit
// one file byte is taken every cycle that byte_stall is low; a byte that makes
// a result reaches the pixel port via the read stage (palette read) and output register
// the byte port stalls only while both the read stage and the output register are full
// reset clears all control state; the palette ram is not cleared, every palette
// entry that a pixel reads is written earlier in the same file
`timescale 1ns / 1ps
`include "bmp_stream_pixel_decoder_assert.svh"

module bmp_stream_pixel_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] file_byte,
	input  logic       file_start,
	output logic       pixel_valid,
	input  logic       pixel_stall,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic       last_pixel,
	output logic [2:0] status
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_PALETTE,
		PH_SKIP,
		PH_PIXELS
	} phase_t;

	localparam int unsigned DW = bspd_pkg::DIM_W;
	localparam int unsigned RW = bspd_pkg::ROW_W;
	localparam int unsigned AW = bspd_pkg::PAL_AW;

	// parse state
	phase_t          phase_q, phase_n;
	logic [31:0]     byte_pos_q, byte_pos_n;
	logic [31:0]     data_offset_q, data_offset_n;
	logic [31:0]     hdr_width_q, hdr_width_n;
	logic [31:0]     hdr_height_q, hdr_height_n;
	logic [15:0]     hdr_bpp_q, hdr_bpp_n;
	logic            hdr_comp_q, hdr_comp_n;
	logic            magic_bad_q, magic_bad_n;
	logic [DW-1:0]   image_width_q, image_width_n;
	logic [DW-1:0]   image_height_q, image_height_n;
	logic            depth8_q, depth8_n;
	logic [RW-1:0]   row_byte_cnt_q, row_byte_cnt_n;
	logic [DW-1:0]   row_cnt_q, row_cnt_n;
	logic [1:0]      rgb_lane_q, rgb_lane_n;
	logic [15:0]     pending_q, pending_n;
	logic [7:0]      pal_blue_q, pal_blue_n;
	logic [7:0]      pal_green_q, pal_green_n;

	// working values of the current byte
	phase_t          ph;
	logic [31:0]     pos;
	logic [5:0]      pos6;
	logic [1:0]      fld_lane;
	logic [9:0]      pal_rel;
	logic [RW-1:0]   row_bytes;
	logic [RW-1:0]   row_padded;
	logic [RW:0]     cnt_inc;
	logic            row_end;
	logic            is_last;

	// result of the current byte
	logic            res_valid;
	logic            res_pal;
	logic [7:0]      res_red, res_green, res_blue;
	logic            res_last;
	bspd_pkg::status_t res_status;
	logic            wr_req, rd_req;

	// palette ram
	logic            ram_we, ram_re;
	logic [AW-1:0]   ram_waddr;
	logic [bspd_pkg::PAL_DW-1:0] ram_wdata, ram_rdata;

	// read stage and output register
	logic            s1_valid_q;
	logic            s1_pal_q;
	logic [7:0]      red_s1, green_s1, blue_s1;
	logic            last_s1;
	bspd_pkg::status_t status_s1;
	logic            out_valid_q;
	logic [7:0]      red_q, green_q, blue_q;
	logic            last_q;
	bspd_pkg::status_t status_q;

	logic            byte_xfer;
	logic            s1_adv;

	assign s1_adv     = !out_valid_q || !pixel_stall;
	assign byte_stall = s1_valid_q && !s1_adv;
	assign byte_xfer  = byte_valid && !byte_stall;

	assign row_bytes  = depth8_q ? {2'b00, image_width_q}
		: RW'({1'b0, image_width_q, 1'b0} + {2'b00, image_width_q});
	assign row_padded = RW'(row_bytes + RW'(3)) & ~RW'(3);

	always_comb begin
		phase_n        = phase_q;
		byte_pos_n     = byte_pos_q;
		data_offset_n  = data_offset_q;
		hdr_width_n    = hdr_width_q;
		hdr_height_n   = hdr_height_q;
		hdr_bpp_n      = hdr_bpp_q;
		hdr_comp_n     = hdr_comp_q;
		magic_bad_n    = magic_bad_q;
		image_width_n  = image_width_q;
		image_height_n = image_height_q;
		depth8_n       = depth8_q;
		row_byte_cnt_n = row_byte_cnt_q;
		row_cnt_n      = row_cnt_q;
		rgb_lane_n     = rgb_lane_q;
		pending_n      = pending_q;
		pal_blue_n     = pal_blue_q;
		pal_green_n    = pal_green_q;

		res_valid  = 1'b0;
		res_pal    = 1'b0;
		res_red    = '0;
		res_green  = '0;
		res_blue   = '0;
		res_last   = 1'b0;
		res_status = bspd_pkg::ST_PIXEL;
		wr_req     = 1'b0;
		rd_req     = 1'b0;
		ram_wdata  = {file_byte, pal_green_q, pal_blue_q};

		ph  = phase_q;
		pos = byte_pos_q;
		if (file_start) begin
			ph            = PH_HEADER;
			phase_n       = PH_HEADER;
			pos           = '0;
			data_offset_n = '0;
			hdr_width_n   = '0;
			hdr_height_n  = '0;
			hdr_bpp_n     = '0;
			hdr_comp_n    = 1'b0;
			magic_bad_n   = 1'b0;
		end
		pos6     = pos[5:0];
		fld_lane = 2'(pos6 - bspd_pkg::POS_OFFSET);
		pal_rel  = pos[9:0] - bspd_pkg::HDR_BYTES[9:0];
		cnt_inc  = {1'b0, row_byte_cnt_q} + 1'b1;
		row_end  = (row_byte_cnt_q == RW'(row_bytes - 1'b1));
		is_last  = row_end && (row_cnt_q == DW'(image_height_q - 1'b1));

		unique case (ph)
			PH_HEADER: begin
				// field bytes land in cleared registers, so each byte is a plain slice write
				case (pos6) inside
					[bspd_pkg::POS_OFFSET:bspd_pkg::POS_OFFSET + 6'd3]:
						data_offset_n[{fld_lane, 3'b000} +: 8] = file_byte;
					[bspd_pkg::POS_WIDTH:bspd_pkg::POS_WIDTH + 6'd3]:
						hdr_width_n[{2'(pos6 - bspd_pkg::POS_WIDTH), 3'b000} +: 8] = file_byte;
					[bspd_pkg::POS_HEIGHT:bspd_pkg::POS_HEIGHT + 6'd3]:
						hdr_height_n[{2'(pos6 - bspd_pkg::POS_HEIGHT), 3'b000} +: 8] =
							file_byte;
					[bspd_pkg::POS_BPP:bspd_pkg::POS_BPP + 6'd1]:
						hdr_bpp_n[{pos6[0], 3'b000} +: 8] = file_byte;
					[bspd_pkg::POS_COMP:bspd_pkg::POS_COMP + 6'd3]:
						if (file_byte != 8'd0) begin
							hdr_comp_n = 1'b1;
						end
					default: ;
				endcase

				if (pos6 == bspd_pkg::POS_MAGIC0) begin
					magic_bad_n = (file_byte != bspd_pkg::MAGIC_B);
				end else if (pos6 == bspd_pkg::POS_MAGIC1) begin
					if (magic_bad_q || file_byte != bspd_pkg::MAGIC_M) begin
						phase_n    = PH_IDLE;
						res_valid  = 1'b1;
						res_status = bspd_pkg::ST_BAD_MAGIC;
					end
				end else if (pos6 == bspd_pkg::POS_LAST) begin
					if (hdr_comp_n) begin
						phase_n    = PH_IDLE;
						res_valid  = 1'b1;
						res_status = bspd_pkg::ST_COMPRESSED;
					end else if (hdr_bpp_n != bspd_pkg::BPP_8 && hdr_bpp_n != bspd_pkg::BPP_24) begin
						phase_n    = PH_IDLE;
						res_valid  = 1'b1;
						res_status = bspd_pkg::ST_BAD_DEPTH;
					end else if (hdr_width_n > bspd_pkg::MAX_DIM
							|| hdr_height_n > bspd_pkg::MAX_DIM) begin
						phase_n    = PH_IDLE;
						res_valid  = 1'b1;
						res_status = bspd_pkg::ST_TOO_LARGE;
					end else if (data_offset_n < ((hdr_bpp_n == bspd_pkg::BPP_8)
							? bspd_pkg::PAL_END_8 : bspd_pkg::HDR_BYTES)) begin
						phase_n    = PH_IDLE;
						res_valid  = 1'b1;
						res_status = bspd_pkg::ST_BAD_OFFSET;
					end else begin
						depth8_n       = (hdr_bpp_n == bspd_pkg::BPP_8);
						image_width_n  = hdr_width_n[DW-1:0];
						image_height_n = hdr_height_n[DW-1:0];
						if (hdr_bpp_n == bspd_pkg::BPP_8) begin
							phase_n = PH_PALETTE;
						end else if (data_offset_n == bspd_pkg::HDR_BYTES) begin
							row_byte_cnt_n = '0;
							row_cnt_n      = '0;
							rgb_lane_n     = '0;
							pending_n      = '0;
							phase_n        = (hdr_width_n[DW-1:0] == '0
								|| hdr_height_n[DW-1:0] == '0) ? PH_IDLE : PH_PIXELS;
						end else begin
							phase_n = PH_SKIP;
						end
					end
				end
			end

			PH_PALETTE: begin
				// blue and green are held until the red byte completes the entry
				case (pal_rel[1:0])
					2'd0:    pal_blue_n  = file_byte;
					2'd1:    pal_green_n = file_byte;
					2'd2:    wr_req      = 1'b1;
					default: ;
				endcase
				if (pal_rel == 10'h3FF) begin
					if (32'(pos + 32'd1) == data_offset_q) begin
						row_byte_cnt_n = '0;
						row_cnt_n      = '0;
						rgb_lane_n     = '0;
						pending_n      = '0;
						phase_n        = (image_width_q == '0 || image_height_q == '0)
							? PH_IDLE : PH_PIXELS;
					end else begin
						phase_n = PH_SKIP;
					end
				end
			end

			PH_SKIP: begin
				if (32'(pos + 32'd1) == data_offset_q) begin
					row_byte_cnt_n = '0;
					row_cnt_n      = '0;
					rgb_lane_n     = '0;
					pending_n      = '0;
					phase_n        = (image_width_q == '0 || image_height_q == '0)
						? PH_IDLE : PH_PIXELS;
				end
			end

			PH_PIXELS: begin
				if (row_byte_cnt_q < row_bytes) begin
					if (depth8_q) begin
						rd_req    = 1'b1;
						res_pal   = 1'b1;
						res_valid = 1'b1;
						res_last  = is_last;
					end else begin
						case (rgb_lane_q)
							2'd0: pending_n = {8'd0, file_byte};
							2'd1: pending_n = {file_byte, pending_q[7:0]};
							default: begin
								res_valid = 1'b1;
								res_last  = is_last;
								res_red   = file_byte;
								res_green = pending_q[15:8];
								res_blue  = pending_q[7:0];
							end
						endcase
						rgb_lane_n = (rgb_lane_q == 2'd2) ? 2'd0 : 2'(rgb_lane_q + 2'd1);
					end
				end
				if (row_byte_cnt_q < row_bytes && is_last) begin
					phase_n = PH_IDLE;
				end else if (cnt_inc >= {1'b0, row_padded}) begin
					row_byte_cnt_n = '0;
					row_cnt_n      = DW'(row_cnt_q + 1'b1);
					rgb_lane_n     = '0;
				end else begin
					row_byte_cnt_n = cnt_inc[RW-1:0];
				end
			end

			PH_IDLE: ;
		endcase

		if (ph != PH_IDLE) begin
			byte_pos_n = 32'(pos + 32'd1);
		end
	end

	assign ram_we    = byte_xfer && wr_req;
	assign ram_re    = byte_xfer && rd_req;
	assign ram_waddr = pal_rel[9:2];

	bspd_ram #(
		.WIDTH (bspd_pkg::PAL_DW),
		.DEPTH (bspd_pkg::PAL_ENTRIES)
	) u_palette (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (file_byte[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			byte_pos_q     <= '0;
			data_offset_q  <= '0;
			hdr_width_q    <= '0;
			hdr_height_q   <= '0;
			hdr_bpp_q      <= '0;
			hdr_comp_q     <= 1'b0;
			magic_bad_q    <= 1'b0;
			image_width_q  <= '0;
			image_height_q <= '0;
			depth8_q       <= 1'b0;
			row_byte_cnt_q <= '0;
			row_cnt_q      <= '0;
			rgb_lane_q     <= '0;
			pending_q      <= '0;
			pal_blue_q     <= '0;
			pal_green_q    <= '0;
			s1_valid_q     <= 1'b0;
			s1_pal_q       <= 1'b0;
			red_s1         <= '0;
			green_s1       <= '0;
			blue_s1        <= '0;
			last_s1        <= 1'b0;
			status_s1      <= bspd_pkg::ST_PIXEL;
			out_valid_q    <= 1'b0;
			red_q          <= '0;
			green_q        <= '0;
			blue_q         <= '0;
			last_q         <= 1'b0;
			status_q       <= bspd_pkg::ST_PIXEL;
		end else begin
			if (byte_xfer) begin
				phase_q        <= phase_n;
				byte_pos_q     <= byte_pos_n;
				data_offset_q  <= data_offset_n;
				hdr_width_q    <= hdr_width_n;
				hdr_height_q   <= hdr_height_n;
				hdr_bpp_q      <= hdr_bpp_n;
				hdr_comp_q     <= hdr_comp_n;
				magic_bad_q    <= magic_bad_n;
				image_width_q  <= image_width_n;
				image_height_q <= image_height_n;
				depth8_q       <= depth8_n;
				row_byte_cnt_q <= row_byte_cnt_n;
				row_cnt_q      <= row_cnt_n;
				rgb_lane_q     <= rgb_lane_n;
				pending_q      <= pending_n;
				pal_blue_q     <= pal_blue_n;
				pal_green_q    <= pal_green_n;
				s1_valid_q     <= res_valid;
				s1_pal_q       <= res_pal;
				red_s1         <= res_red;
				green_s1       <= res_green;
				blue_s1        <= res_blue;
				last_s1        <= res_last;
				status_s1      <= res_status;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end

			// palette data is still on the ram output while the read stage waits
			if (s1_valid_q && s1_adv) begin
				out_valid_q <= 1'b1;
				red_q       <= s1_pal_q ? ram_rdata[23:16] : red_s1;
				green_q     <= s1_pal_q ? ram_rdata[15:8] : green_s1;
				blue_q      <= s1_pal_q ? ram_rdata[7:0] : blue_s1;
				last_q      <= last_s1;
				status_q    <= status_s1;
			end else if (out_valid_q && !pixel_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign pixel_valid = out_valid_q;
	assign red         = red_q;
	assign green       = green_q;
	assign blue        = blue_q;
	assign last_pixel  = last_q;
	assign status      = status_q;

	`BSPD_ASSERT(a_err_no_pal, s1_valid_q && status_s1 != bspd_pkg::ST_PIXEL, !last_s1 && !s1_pal_q)
	`BSPD_ASSERT(a_rw_disjoint, ram_we, !ram_re)
	`BSPD_ASSERT(a_read_8bit, ram_re, depth8_q && phase_q == PH_PIXELS && !file_start)
	`BSPD_ASSERT_NEXT(a_last_idle, byte_xfer && res_valid && res_last, phase_q == PH_IDLE)
	`BSPD_ASSERT_NEXT(a_s1_hold, s1_valid_q && !s1_adv, s1_valid_q)

endmodule

@@ sv/bspd_ram.sv @@
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps

module bspd_ram #(
	parameter int unsigned WIDTH  = 24,
	parameter int unsigned DEPTH  = 256,
	parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
